>>> design/rom_dialect_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// rom dialect classifier assertion macros
// shorthand for clocked assertions that are gated off during reset
// ----------------------------------------------------------------------------
`ifndef ROM_DIALECT_CLASSIFIER_UNIT_ASSERT_SVH
`define ROM_DIALECT_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define RDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// shared types, opcode patterns and decision constants of the rom classifier
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int SCORE_WIDTH = 16;

  typedef logic [SCORE_WIDTH-1:0] score_t;
  typedef logic [SCORE_WIDTH:0]   score_sum_t;

  typedef struct packed {
    score_t super_count;
    score_t vip_score;
    score_t chip48_score;
  } scores_t;

  // opcode classification flags
  typedef struct packed {
    logic super_hit;
    logic vip3_hit;
    logic vip2_hit;
    logic chip48_hit;
  } op_class_t;

  typedef enum logic [1:0] {
    DIALECT_BASE   = 2'd0,
    DIALECT_CHIP48 = 2'd1,
    DIALECT_SUPER  = 2'd2
  } dialect_t;

  typedef enum logic [1:0] {
    PROFILE_MODERN   = 2'd0,
    PROFILE_ORIGINAL = 2'd1,
    PROFILE_CHIP48   = 2'd2
  } profile_t;

  typedef struct packed {
    dialect_t   dialect;
    profile_t   profile;
    logic [6:0] confidence;
  } result_t;

  // opcode patterns
  localparam logic [15:0] OP_SUPER_LO   = 16'h00FB;
  localparam logic [15:0] OP_SUPER_HI   = 16'h00FF;
  localparam logic [15:0] MASK_SCROLL   = 16'hFFF0;
  localparam logic [15:0] OP_SCROLL     = 16'h00C0;
  localparam logic [15:0] MASK_DRAW     = 16'hF00F;
  localparam logic [15:0] OP_DRAW16     = 16'hD000;
  localparam logic [15:0] MASK_FX       = 16'hF0FF;
  localparam logic [15:0] OP_FX30       = 16'hF030;
  localparam logic [15:0] OP_FX75       = 16'hF075;
  localparam logic [15:0] OP_FX85       = 16'hF085;
  localparam logic [15:0] OP_CLS        = 16'h00E0;
  localparam logic [15:0] OP_RET        = 16'h00EE;
  localparam logic [3:0]  NIB_SYS       = 4'h0;
  localparam logic [3:0]  NIB_ALU       = 4'h8;
  localparam logic [3:0]  NIB_JUMP_OFS  = 4'hB;
  localparam logic [3:0]  ALU_SHR       = 4'h6;
  localparam logic [3:0]  ALU_SHL       = 4'hE;

  // score increments
  localparam logic [1:0] INC_SUPER  = 2'd1;
  localparam logic [1:0] INC_VIP_SYS = 2'd3;
  localparam logic [1:0] INC_VIP_ALU = 2'd2;
  localparam logic [1:0] INC_CHIP48 = 2'd3;
  localparam int         MARGIN     = 2;

  // confidence bases and caps
  localparam int CONF_SUPER_BASE  = 88;
  localparam int CONF_SUPER_CAP   = 99;
  localparam int CONF_CHIP48_BASE = 62;
  localparam int CONF_CHIP48_CAP  = 90;
  localparam int CONF_VIP_BASE    = 60;
  localparam int CONF_VIP_CAP     = 88;
  localparam int CONF_NEUTRAL     = 55;

  // score beyond which the cap applies
  localparam int SUPER_KNEE  = (CONF_SUPER_CAP - CONF_SUPER_BASE) / 2;
  localparam int CHIP48_KNEE = (CONF_CHIP48_CAP - CONF_CHIP48_BASE) / 4;
  localparam int VIP_KNEE    = (CONF_VIP_CAP - CONF_VIP_BASE) / 4;

  function automatic score_t sat_add(score_t s, logic [1:0] k);
    score_sum_t t;
    t = {1'b0, s} + score_sum_t'(k);
    return t[SCORE_WIDTH] ? '1 : t[SCORE_WIDTH-1:0];
  endfunction

endpackage

>>> design/rom_dialect_classifier_unit.sv
// ----------------------------------------------------------------------------
// rom_dialect_classifier_unit
// Takes one program byte per cycle and reports the detected dialect of an
// image when its last byte is seen. A byte is registered on input, scored in
// the following cycle and, if it is the last one, its result is registered on
// the output. The rate is one byte per cycle while the input is not stalled.
// Only a last byte waits on a result still held at the output; while it waits,
// the input is stalled and no other byte passes.
// ----------------------------------------------------------------------------
module rom_dialect_classifier_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rom_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] dialect,
  output logic [1:0] profile,
  output logic [6:0] confidence
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             step;
  rdc_pkg::scores_t scores_next;
  rdc_pkg::result_t result;

  // a last beat may only retire when the output register is free
  assign in_ready = !s1_valid || !s1_last || !out_valid || out_ready;
  assign step     = s1_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rom_byte;
      s1_last <= last_byte;
    end
  end

  rdc_score u_score (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rom_byte    (s1_byte),
    .last_byte   (s1_last),
    .scores_next (scores_next)
  );

  rdc_decide u_decide (
    .scores (scores_next),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      dialect    <= result.dialect;
      profile    <= result.profile;
      confidence <= result.confidence;
    end
  end

endmodule

>>> design/rdc_decode.sv
// ----------------------------------------------------------------------------
// rdc_decode
// classifies one 16-bit opcode into the dialect score categories
// ----------------------------------------------------------------------------
module rdc_decode (
  input  logic [15:0]           opcode,
  output rdc_pkg::op_class_t    op_class
);

  logic [3:0] hi_nib;
  logic [3:0] x_nib;
  logic [3:0] y_nib;
  logic [3:0] z_nib;
  logic       super_hit;

  assign hi_nib = opcode[15:12];
  assign x_nib  = opcode[11:8];
  assign y_nib  = opcode[7:4];
  assign z_nib  = opcode[3:0];

  always_comb begin
    super_hit = (opcode inside {[rdc_pkg::OP_SUPER_LO:rdc_pkg::OP_SUPER_HI]})
             || ((opcode & rdc_pkg::MASK_SCROLL) == rdc_pkg::OP_SCROLL)
             || ((opcode & rdc_pkg::MASK_DRAW) == rdc_pkg::OP_DRAW16)
             || ((opcode & rdc_pkg::MASK_FX) inside
                 {rdc_pkg::OP_FX30, rdc_pkg::OP_FX75, rdc_pkg::OP_FX85});

    op_class.super_hit  = super_hit;
    // machine-code calls count only when not already a super opcode
    op_class.vip3_hit   = !super_hit && (hi_nib == rdc_pkg::NIB_SYS)
                       && !(opcode inside {16'h0000, rdc_pkg::OP_CLS, rdc_pkg::OP_RET});
    op_class.vip2_hit   = (hi_nib == rdc_pkg::NIB_ALU)
                       && (z_nib inside {rdc_pkg::ALU_SHR, rdc_pkg::ALU_SHL})
                       && (x_nib != y_nib);
    op_class.chip48_hit = (hi_nib == rdc_pkg::NIB_JUMP_OFS) && (x_nib != 4'h0);
  end

endmodule

>>> design/rdc_score.sv
// ----------------------------------------------------------------------------
// rdc_score
// byte pairing and saturating score registers for one image
// ----------------------------------------------------------------------------
module rdc_score (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rom_byte,
  input  logic              last_byte,
  output rdc_pkg::scores_t  scores_next
);

  logic               odd_phase;
  logic [7:0]         held_high_byte;
  rdc_pkg::scores_t   scores;
  rdc_pkg::op_class_t op_class;
  logic [1:0]         vip_inc;

  rdc_decode u_decode (
    .opcode   ({held_high_byte, rom_byte}),
    .op_class (op_class)
  );

  always_comb begin
    vip_inc = 2'd0;
    if (op_class.vip3_hit) begin
      vip_inc = rdc_pkg::INC_VIP_SYS;
    end else if (op_class.vip2_hit) begin
      vip_inc = rdc_pkg::INC_VIP_ALU;
    end

    scores_next = scores;
    // low byte completes an opcode
    if (odd_phase) begin
      if (op_class.super_hit) begin
        scores_next.super_count = rdc_pkg::sat_add(scores.super_count, rdc_pkg::INC_SUPER);
      end
      scores_next.vip_score = rdc_pkg::sat_add(scores.vip_score, vip_inc);
      if (op_class.chip48_hit) begin
        scores_next.chip48_score =
          rdc_pkg::sat_add(scores.chip48_score, rdc_pkg::INC_CHIP48);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      odd_phase      <= 1'b0;
      held_high_byte <= 8'h00;
      scores         <= '0;
    end else if (step) begin
      if (last_byte) begin
        odd_phase      <= 1'b0;
        held_high_byte <= 8'h00;
        scores         <= '0;
      end else begin
        odd_phase <= !odd_phase;
        if (!odd_phase) begin
          held_high_byte <= rom_byte;
        end
        scores <= scores_next;
      end
    end
  end

endmodule

>>> design/rdc_decide.sv
// ----------------------------------------------------------------------------
// rdc_decide
// turns the final scores into dialect, quirk profile and confidence
// ----------------------------------------------------------------------------
module rdc_decide (
  input  rdc_pkg::scores_t  scores,
  output rdc_pkg::result_t  result
);

  rdc_pkg::score_sum_t sc_ext;
  rdc_pkg::score_sum_t vp_ext;
  rdc_pkg::score_sum_t c4_ext;

  always_comb begin
    sc_ext = {1'b0, scores.super_count};
    vp_ext = {1'b0, scores.vip_score};
    c4_ext = {1'b0, scores.chip48_score};

    if (sc_ext != '0) begin
      result.dialect = rdc_pkg::DIALECT_SUPER;
      result.profile = rdc_pkg::PROFILE_CHIP48;
      if (sc_ext > rdc_pkg::score_sum_t'(rdc_pkg::SUPER_KNEE)) begin
        result.confidence = 7'(rdc_pkg::CONF_SUPER_CAP);
      end else begin
        result.confidence = 7'(rdc_pkg::CONF_SUPER_BASE)
                          + {3'b000, scores.super_count[2:0], 1'b0};
      end
    end else if (c4_ext >= vp_ext + rdc_pkg::score_sum_t'(rdc_pkg::MARGIN)) begin
      result.dialect = rdc_pkg::DIALECT_CHIP48;
      result.profile = rdc_pkg::PROFILE_CHIP48;
      if (c4_ext > rdc_pkg::score_sum_t'(rdc_pkg::CHIP48_KNEE)) begin
        result.confidence = 7'(rdc_pkg::CONF_CHIP48_CAP);
      end else begin
        result.confidence = 7'(rdc_pkg::CONF_CHIP48_BASE)
                          + {2'b00, scores.chip48_score[2:0], 2'b00};
      end
    end else if (vp_ext >= c4_ext + rdc_pkg::score_sum_t'(rdc_pkg::MARGIN)) begin
      result.dialect = rdc_pkg::DIALECT_BASE;
      result.profile = rdc_pkg::PROFILE_ORIGINAL;
      if (vp_ext > rdc_pkg::score_sum_t'(rdc_pkg::VIP_KNEE)) begin
        result.confidence = 7'(rdc_pkg::CONF_VIP_CAP);
      end else begin
        result.confidence = 7'(rdc_pkg::CONF_VIP_BASE)
                          + {2'b00, scores.vip_score[2:0], 2'b00};
      end
    end else begin
      result.dialect    = rdc_pkg::DIALECT_BASE;
      result.profile    = rdc_pkg::PROFILE_MODERN;
      result.confidence = 7'(rdc_pkg::CONF_NEUTRAL);
    end
  end

endmodule

>>> design/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// port-level checks on the result channel of the rom classifier
// ----------------------------------------------------------------------------
`include "rom_dialect_classifier_unit_assert.svh"

module rdc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] dialect,
  input logic [1:0] profile,
  input logic [6:0] confidence
);

  `RDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({dialect, profile, confidence}), "result changed while stalled")
  `RDC_ASSERT_NOW(a_super_pair, out_valid && dialect == rdc_pkg::DIALECT_SUPER, profile == rdc_pkg::PROFILE_CHIP48 && confidence >= 7'd90 && confidence <= 7'd99, "super result out of range")
  `RDC_ASSERT_NOW(a_chip48_pair, out_valid && dialect == rdc_pkg::DIALECT_CHIP48, profile == rdc_pkg::PROFILE_CHIP48 && confidence >= 7'd62 && confidence <= 7'd90, "forty-eight result out of range")
  `RDC_ASSERT_NOW(a_base_pair, out_valid && dialect == rdc_pkg::DIALECT_BASE, (profile == rdc_pkg::PROFILE_ORIGINAL && confidence >= 7'd60 && confidence <= 7'd88) || (profile == rdc_pkg::PROFILE_MODERN && confidence == 7'd55), "base result inconsistent")

endmodule

bind rom_dialect_classifier_unit rdc_checker u_rdc_checker (.*);

>>> tb/sv/tb_rom_dialect_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_rom_dialect_classifier_unit
// Self-checking bench for the rom dialect classifier. Program images go in as
// byte beats with random gaps. An in-bench scorer pairs the bytes into opcodes,
// keeps the three saturating scores and predicts the verdict for every image.
// Each result beat is checked field by field against the oldest prediction.
// The output side stalls at random, and once holds off long enough for the
// block to back up into its input.
// ----------------------------------------------------------------------------
module tb_rom_dialect_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;

  localparam int          RANDOM_BYTES   = 1620;
  localparam int          HOLD_AT        = 400;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          MAX_REPORTS    = 10;
  localparam int          DRAIN_CYCLES   = 8;
  localparam longint unsigned SCORE_MAX  = (64'd1 << SCORE_WIDTH) - 1;

  typedef struct {
    logic [7:0] value;
    logic       last;
    bit         quick;
  } rom_beat_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rom_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] dialect;
  logic [1:0] profile;
  logic [6:0] confidence;

  rom_dialect_classifier_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rom_byte   (rom_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dialect    (dialect),
    .profile    (profile),
    .confidence (confidence)
  );

  rom_beat_t   pending_bytes[$];
  result_t     expected_verdicts[$];
  int unsigned bytes_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned fail_count = 0;
  int unsigned dialect_hits[3] = '{0, 0, 0};
  logic        hold_off = 1'b0;

  // scorer state, mirrors what the block accumulates for the current image
  logic [7:0]  pair_hi = 8'h00;
  bit          pair_open = 1'b0;
  score_t      n_super = '0;
  score_t      n_vip = '0;
  score_t      n_chip48 = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic score_t sat_bump(score_t s, int unsigned k);
    longint unsigned t;
    t = longint'(s) + k;
    return (t > SCORE_MAX) ? score_t'(SCORE_MAX) : score_t'(t);
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic void tally_opcode(logic [15:0] op);
    logic [3:0] top, x, y, z;
    bit         is_super;
    top = op[15:12];
    x   = op[11:8];
    y   = op[7:4];
    z   = op[3:0];
    is_super = (op >= OP_SUPER_LO && op <= OP_SUPER_HI) ||
               ((op & MASK_SCROLL) == OP_SCROLL) ||
               ((op & MASK_DRAW) == OP_DRAW16) ||
               ((op & MASK_FX) == OP_FX30) ||
               ((op & MASK_FX) == OP_FX75) ||
               ((op & MASK_FX) == OP_FX85);
    if (is_super)
      n_super = sat_bump(n_super, 1);
    else if (top == NIB_SYS && op != 16'h0000 && op != OP_CLS && op != OP_RET)
      n_vip = sat_bump(n_vip, 3);
    if (top == NIB_ALU && (z == ALU_SHR || z == ALU_SHL) && x != y)
      n_vip = sat_bump(n_vip, 2);
    if (top == NIB_JUMP_OFS && x != 4'h0)
      n_chip48 = sat_bump(n_chip48, 3);
  endfunction

  function automatic result_t decide_dialect();
    longint unsigned sc, vp, c4;
    result_t         r;
    sc = n_super;
    vp = n_vip;
    c4 = n_chip48;
    if (sc != 0) begin
      r.dialect    = DIALECT_SUPER;
      r.profile    = PROFILE_CHIP48;
      r.confidence = 7'(clip(CONF_SUPER_BASE + 2 * sc, CONF_SUPER_CAP));
    end else if (c4 >= vp + MARGIN) begin
      r.dialect    = DIALECT_CHIP48;
      r.profile    = PROFILE_CHIP48;
      r.confidence = 7'(clip(CONF_CHIP48_BASE + 4 * c4, CONF_CHIP48_CAP));
    end else if (vp >= c4 + MARGIN) begin
      r.dialect    = DIALECT_BASE;
      r.profile    = PROFILE_ORIGINAL;
      r.confidence = 7'(clip(CONF_VIP_BASE + 4 * vp, CONF_VIP_CAP));
    end else begin
      r.dialect    = DIALECT_BASE;
      r.profile    = PROFILE_MODERN;
      r.confidence = 7'(CONF_NEUTRAL);
    end
    return r;
  endfunction

  // returns 1 when the byte closes an image and a verdict is due
  function automatic bit classify_byte(logic [7:0] b, logic last, output result_t r);
    r = '0;
    if (!pair_open) begin
      pair_hi   = b;
      pair_open = 1'b1;
    end else begin
      tally_opcode({pair_hi, b});
      pair_open = 1'b0;
    end
    if (!last)
      return 1'b0;
    r = decide_dialect();
    pair_hi   = 8'h00;
    pair_open = 1'b0;
    n_super   = '0;
    n_vip     = '0;
    n_chip48  = '0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap(bit quick);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quick)
      return (r < 10) ? 1 : 0;
    if (r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic void add_byte(logic [7:0] b, bit quick = 1'b0);
    rom_beat_t t;
    t.value = b;
    t.last  = 1'b0;
    t.quick = quick;
    pending_bytes.push_back(t);
  endfunction

  function automatic void add_op(logic [15:0] op, bit quick = 1'b0);
    add_byte(op[15:8], quick);
    add_byte(op[7:0], quick);
  endfunction

  function automatic void end_image();
    rom_beat_t t;
    t = pending_bytes.pop_back();
    t.last = 1'b1;
    pending_bytes.push_back(t);
  endfunction

  // themes: 0 raw noise, 1 any kind, 2 no super op forms picked on purpose, 3 jump-offset heavy, 4 vip heavy
  function automatic logic [15:0] make_op(int unsigned theme);
    int unsigned k;
    logic [3:0]  x, y;
    x = 4'($urandom);
    y = ($urandom_range(0, 3) == 0) ? x : 4'($urandom);
    k = $urandom_range(0, 9);
    if (theme == 0)
      return 16'($urandom);
    if (theme == 3)
      k = (k < 7) ? 6 : 8;
    else if (theme == 4)
      k = (k < 7) ? 2 + (k % 4) : 8;
    else if (theme == 2 && k < 2)
      k = 6;
    case (k)
      0, 1: begin
        case ($urandom_range(0, 3))
          0: return OP_SUPER_LO + 16'($urandom_range(0, 4));
          1: return OP_SCROLL | 16'($urandom_range(0, 15));
          2: return OP_DRAW16 | {4'h0, x, y, 4'h0};
          default: begin
            case ($urandom_range(0, 2))
              0: return OP_FX30 | {4'h0, x, 8'h00};
              1: return OP_FX75 | {4'h0, x, 8'h00};
              default: return OP_FX85 | {4'h0, x, 8'h00};
            endcase
          end
        endcase
      end
      2, 3: return {NIB_SYS, 12'($urandom)};
      4, 5: return {NIB_ALU, x, y, ($urandom_range(0, 1) != 0) ? ALU_SHR : ALU_SHL};
      6, 7: return {NIB_JUMP_OFS, x, 8'($urandom)};
      8: begin
        case ($urandom_range(0, 2))
          0: return OP_CLS;
          1: return OP_RET;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // byte driver
  always @(posedge clk) begin : drive
    int unsigned gap_left;
    bit          in_calm;
    rom_beat_t   beat;
    result_t     verdict;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      in_calm  = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_taken++;
        if (classify_byte(rom_byte, last_byte, verdict))
          expected_verdicts.push_back(verdict);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          beat = pending_bytes.pop_front();
          rom_byte  <= beat.value;
          last_byte <= beat.last;
          in_valid  <= 1'b1;
          if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
          gap_left = in_calm ? 0 : pick_gap(beat.quick);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stalls
  always @(posedge clk) begin : watch
    int unsigned stall_left;
    bit          out_calm;
    result_t     want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      out_calm   = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (dialect < 3)
          dialect_hits[dialect]++;
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result beat: dialect=%0d profile=%0d confidence=%0d",
                     dialect, profile, confidence);
        end else begin
          want = expected_verdicts.pop_front();
          if (dialect !== want.dialect || profile !== want.profile ||
              confidence !== want.confidence) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch on image %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       verdicts_seen, want.dialect, want.profile, want.confidence,
                       dialect, profile, confidence);
          end
        end
      end
      if ($urandom_range(0, 199) == 0)
        out_calm = !out_calm;
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 4) == 0)
          stall_left = pick_gap(1'b0);
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (bytes_taken >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    int unsigned idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_verdicts.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    int unsigned total_bytes;
    int unsigned theme;
    int unsigned n_ops;

    // single-byte image: no opcode at all
    add_byte(8'hFF);
    end_image();
    // jump-offset op followed by a trailing odd byte that must be ignored
    add_op(16'hB123);
    add_byte(8'h00);
    end_image();
    // system call plus shifts, one with x equal to y
    add_op(16'h0123);
    add_op(16'h8126);
    add_op(16'h822E);
    end_image();
    // clear, return, zero opcode and jump-offset with x zero score nothing
    add_op(16'h00E0);
    add_op(16'h00EE);
    add_op(16'h0000);
    add_op(16'hB0FF);
    end_image();
    // each super op form except the 00FB-00FF range
    add_op(16'hD120);
    add_op(16'hF230);
    add_op(16'hF375);
    add_op(16'hF485);
    add_op(16'h00C5);
    end_image();

    random_start = pending_bytes.size();
    while (pending_bytes.size() - random_start < RANDOM_BYTES) begin
      theme = $urandom_range(0, 4);
      n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      for (int i = 0; i < n_ops; i++)
        add_op(make_op(theme));
      if (n_ops == 0 || $urandom_range(0, 3) == 0)
        add_byte(8'($urandom));
      end_image();
    end

    total_bytes = pending_bytes.size();
    while (bytes_taken < total_bytes || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d images over %0d bytes: %0d base, %0d forty-eight, %0d super",
             verdicts_seen, bytes_taken, dialect_hits[0], dialect_hits[1], dialect_hits[2]);
    $display("covered every opcode class, odd trailing bytes, confidence caps and %0s",
             "a long output hold-off");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d result beats failed", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
